// File: src/mfd_pkg.sv
// Package for the motor feedback frame decoder.
// Holds item, configuration and pipeline types, register indexes and the
// constant divider used by the linear scaling. No dependencies.
`timescale 1ns / 1ps

package mfd_pkg;

  localparam int unsigned CFG_W = 23;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_MOTOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT   = 3'd5;

  localparam logic [10:0] RST_FEEDBACK_ID    = 11'd0;
  localparam logic [3:0]  RST_EXPECTED_MOTOR = 4'd1;
  localparam logic [15:0] RST_TIMEOUT_MS     = 16'd100;
  localparam logic [22:0] RST_POSITION_LIMIT = 23'd816553;
  localparam logic [22:0] RST_VELOCITY_LIMIT = 23'd1966080;
  localparam logic [22:0] RST_TORQUE_LIMIT   = 23'd655360;

  localparam logic [1:0] ST_TICK        = 2'd0;
  localparam logic [1:0] ST_ACCEPTED    = 2'd1;
  localparam logic [1:0] ST_BAD_HEADER  = 2'd2;
  localparam logic [1:0] ST_WRONG_MOTOR = 2'd3;

  localparam logic [3:0] FRAME_LEN = 4'd8;

  localparam int unsigned POS_CODE_W = 16;
  localparam int unsigned VT_CODE_W  = 12;
  localparam int unsigned PROD_W     = 40;

  typedef struct packed {
    logic [10:0] feedback_id;
    logic [3:0]  expected_motor;
    logic [15:0] timeout_ms;
    logic [22:0] position_limit;
    logic [22:0] velocity_limit;
    logic [22:0] torque_limit;
  } mfd_cfg_t;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic        extended_id;
    logic [10:0] frame_id;
    logic [3:0]  length_code;
    logic [63:0] payload;
  } mfd_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              take;
    logic [3:0]        motor;
    logic [3:0]        fault;
    logic [7:0]        mos_temp;
    logic [7:0]        rotor_temp;
    logic              online;
    logic [31:0]       good_count;
    logic [31:0]       bad_count;
    logic [PROD_W-1:0] pos_prod;
    logic [PROD_W-1:0] vel_prod;
    logic [PROD_W-1:0] trq_prod;
  } mfd_snap_t;

  typedef struct packed {
    logic [1:0]         frame_status;
    logic [3:0]         motor_nibble;
    logic [3:0]         fault_nibble;
    logic signed [23:0] position;
    logic signed [23:0] velocity;
    logic signed [23:0] torque;
    logic [7:0]         mos_temp;
    logic [7:0]         rotor_temp;
    logic               online;
    logic [31:0]        good_count;
    logic [31:0]        bad_count;
  } mfd_res_t;

  // floor(p / (2^w - 1)) for p < 2^(3w): series estimate, then one correction
  function automatic logic [23:0] div_full(input logic [PROD_W-1:0] p, input int unsigned w);
    logic [PROD_W+1:0] s;
    logic [PROD_W+1:0] r;
    logic [PROD_W+1:0] full;
    logic [25:0]       q0;
    s    = (PROD_W+2)'(p) + (PROD_W+2)'(p >> w) + (PROD_W+2)'(p >> (2 * w));
    q0   = 26'(s >> w);
    r    = (PROD_W+2)'(p) - ((PROD_W+2)'(q0) << w) + (PROD_W+2)'(q0);
    full = ((PROD_W+2)'(1) << w) - (PROD_W+2)'(1);
    if (r >= full) begin
      q0 = q0 + 26'd1;
    end
    return q0[23:0];
  endfunction

endpackage

// File: src/mfd_feedback_if.sv
// Channel carrying received feedback frames and time ticks.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface mfd_feedback_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] now_ms;
  logic        extended_id;
  logic [10:0] frame_id;
  logic [3:0]  length_code;
  logic [63:0] payload;

  modport source (
    output valid, command, now_ms, extended_id, frame_id, length_code, payload,
    input  ready
  );
  modport sink (
    input  valid, command, now_ms, extended_id, frame_id, length_code, payload,
    output ready
  );
endinterface

// File: src/mfd_decoded_if.sv
// Channel carrying one decoded result per feedback transaction.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface mfd_decoded_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic [3:0]         motor_nibble;
  logic [3:0]         fault_nibble;
  logic signed [23:0] position;
  logic signed [23:0] velocity;
  logic signed [23:0] torque;
  logic [7:0]         mos_temp;
  logic [7:0]         rotor_temp;
  logic               online;
  logic [31:0]        good_count;
  logic [31:0]        bad_count;

  modport source (
    output valid, frame_status, motor_nibble, fault_nibble, position, velocity, torque,
           mos_temp, rotor_temp, online, good_count, bad_count,
    input  ready
  );
  modport sink (
    input  valid, frame_status, motor_nibble, fault_nibble, position, velocity, torque,
           mos_temp, rotor_temp, online, good_count, bad_count,
    output ready
  );
endinterface

// File: src/mfd_ctrl.sv
// Header check, motor match, counters, online timeout and code products.
// Holds the control state of the decoder. Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_ctrl import mfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mfd_cfg_t  cfg,
  input  mfd_in_t   item,
  input  logic      step,
  output mfd_snap_t snap
);

  logic [31:0] last_rx;
  logic        online;
  logic [31:0] good;
  logic [31:0] bad;
  logic [3:0]  motor;
  logic [3:0]  fault;
  logic [7:0]  mos;
  logic [7:0]  rotor;

  logic [31:0] last_rx_next;
  logic        online_next;
  logic [31:0] good_next;
  logic [31:0] bad_next;
  logic [3:0]  motor_next;
  logic [3:0]  fault_next;
  logic [7:0]  mos_next;
  logic [7:0]  rotor_next;

  logic        hdr_ok;
  logic        take;
  logic [1:0]  status;
  logic [3:0]  motor_in;
  logic [31:0] elapsed;
  logic        online_pre;
  logic [POS_CODE_W-1:0] pos_code;
  logic [VT_CODE_W-1:0]  vel_code;
  logic [VT_CODE_W-1:0]  trq_code;

  assign motor_in = item.payload[59:56];
  assign pos_code = item.payload[55:40];
  assign vel_code = item.payload[39:28];
  assign trq_code = item.payload[27:16];

  assign hdr_ok = !item.extended_id && (item.frame_id == cfg.feedback_id)
                  && (item.length_code == FRAME_LEN);
  assign take = item.command && hdr_ok && (motor_in == cfg.expected_motor);

  always_comb begin
    status     = ST_TICK;
    good_next  = good;
    bad_next   = bad;
    motor_next = motor;
    fault_next = fault;
    mos_next   = mos;
    rotor_next = rotor;
    last_rx_next = last_rx;
    online_pre   = online;
    if (item.command) begin
      if (!hdr_ok) begin
        status   = ST_BAD_HEADER;
        bad_next = bad + 32'd1;
      end else begin
        motor_next = motor_in;
        fault_next = item.payload[63:60];
        if (!take) begin
          status   = ST_WRONG_MOTOR;
          bad_next = bad + 32'd1;
        end else begin
          status       = ST_ACCEPTED;
          good_next    = good + 32'd1;
          mos_next     = item.payload[15:8];
          rotor_next   = item.payload[7:0];
          last_rx_next = item.now_ms;
          online_pre   = 1'b1;
        end
      end
    end
    elapsed     = item.now_ms - last_rx_next;
    online_next = online_pre && !(elapsed > {16'd0, cfg.timeout_ms});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_rx <= '0;
      online  <= 1'b0;
      good    <= '0;
      bad     <= '0;
      motor   <= '0;
      fault   <= '0;
      mos     <= '0;
      rotor   <= '0;
    end else if (step) begin
      last_rx <= last_rx_next;
      online  <= online_next;
      good    <= good_next;
      bad     <= bad_next;
      motor   <= motor_next;
      fault   <= fault_next;
      mos     <= mos_next;
      rotor   <= rotor_next;
    end
  end

  always_comb begin
    snap.status     = status;
    snap.take       = take;
    snap.motor      = motor_next;
    snap.fault      = fault_next;
    snap.mos_temp   = mos_next;
    snap.rotor_temp = rotor_next;
    snap.online     = online_next;
    snap.good_count = good_next;
    snap.bad_count  = bad_next;
    snap.pos_prod   = PROD_W'(pos_code) * PROD_W'({cfg.position_limit, 1'b0});
    snap.vel_prod   = PROD_W'(vel_code) * PROD_W'({cfg.velocity_limit, 1'b0});
    snap.trq_prod   = PROD_W'(trq_code) * PROD_W'({cfg.torque_limit, 1'b0});
  end

  a_take_online: assert property (@(posedge clk) disable iff (rst)
    step && take |=> online)
    else $error("online not set after accepted frame");

  a_reject_count: assert property (@(posedge clk) disable iff (rst)
    step && (status == ST_BAD_HEADER || status == ST_WRONG_MOTOR)
    |=> bad == $past(bad) + 32'd1 && good == $past(good))
    else $error("rejected frame not counted");

  a_tick_hold: assert property (@(posedge clk) disable iff (rst)
    step && status == ST_TICK
    |=> good == $past(good) && bad == $past(bad) && last_rx == $past(last_rx))
    else $error("tick changed frame state");

endmodule

// File: src/mfd_scale.sv
// Scaling stage: divides the code products by the code full scale,
// removes the offset and holds the last position, velocity and torque.
// Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_scale import mfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mfd_cfg_t  cfg,
  input  mfd_snap_t snap,
  input  logic      step,
  output mfd_res_t  res
);

  logic signed [23:0] position;
  logic signed [23:0] velocity;
  logic signed [23:0] torque;
  logic signed [23:0] pos_new;
  logic signed [23:0] vel_new;
  logic signed [23:0] trq_new;

  assign pos_new = div_full(snap.pos_prod, POS_CODE_W) - {1'b0, cfg.position_limit};
  assign vel_new = div_full(snap.vel_prod, VT_CODE_W) - {1'b0, cfg.velocity_limit};
  assign trq_new = div_full(snap.trq_prod, VT_CODE_W) - {1'b0, cfg.torque_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      velocity <= '0;
      torque   <= '0;
    end else if (step && snap.take) begin
      position <= pos_new;
      velocity <= vel_new;
      torque   <= trq_new;
    end
  end

  always_comb begin
    res.frame_status = snap.status;
    res.motor_nibble = snap.motor;
    res.fault_nibble = snap.fault;
    res.position     = snap.take ? pos_new : position;
    res.velocity     = snap.take ? vel_new : velocity;
    res.torque       = snap.take ? trq_new : torque;
    res.mos_temp     = snap.mos_temp;
    res.rotor_temp   = snap.rotor_temp;
    res.online       = snap.online;
    res.good_count   = snap.good_count;
    res.bad_count    = snap.bad_count;
  end

  a_hold_values: assert property (@(posedge clk) disable iff (rst)
    step && !snap.take |=> position == $past(position) && torque == $past(torque))
    else $error("scaled values changed without accepted frame");

endmodule

// File: src/motor_feedback_frame_decoder.sv
// Motor feedback frame decoder, top level.
// Usage:
//   feedback: one transaction per time tick (command 0) or received CAN
//     frame (command 1); accepted when valid and ready are both high.
//   decoded: exactly one result transaction per feedback transaction, in
//     order, carrying status and the full current state after that item.
//   cfg_we/cfg_index/cfg_data: register writes, taken on any edge with
//     cfg_we high; write only while the block is idle. Index 0 feedback id,
//     1 expected motor, 2 timeout, 3..5 position/velocity/torque limits.
// Pipeline: the accept edge loads the input register; the item then moves to
//   the check and multiply register, and the divide-by-full-scale result
//   goes into the output register.
// Throughput: one transaction per cycle while decoded.ready is high; each of
//   the three stages takes an item when its register is empty or moving on.
// Stall: when decoded.ready is low the output register holds its result;
//   earlier stages keep filling until each holds one item, then
//   feedback.ready drops.
// Reset (rst, synchronous): pipeline empties, counters, timestamps and held
//   values clear, registers return to their defaults.
// Depends on mfd_pkg, mfd_feedback_if, mfd_decoded_if, mfd_ctrl, mfd_scale.
`timescale 1ns / 1ps

module motor_feedback_frame_decoder import mfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  mfd_feedback_if.sink         feedback,
  mfd_decoded_if.source        decoded
);

  mfd_cfg_t  cfg;
  mfd_in_t   a_item;
  logic      a_valid;
  mfd_snap_t snap;
  mfd_snap_t b_snap;
  logic      b_valid;
  mfd_res_t  res;
  mfd_res_t  out_res;
  logic      out_valid;
  logic      a_ready;
  logic      b_ready;
  logic      c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.feedback_id    <= RST_FEEDBACK_ID;
      cfg.expected_motor <= RST_EXPECTED_MOTOR;
      cfg.timeout_ms     <= RST_TIMEOUT_MS;
      cfg.position_limit <= RST_POSITION_LIMIT;
      cfg.velocity_limit <= RST_VELOCITY_LIMIT;
      cfg.torque_limit   <= RST_TORQUE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FEEDBACK_ID:    cfg.feedback_id    <= cfg_data[10:0];
        REG_EXPECTED_MOTOR: cfg.expected_motor <= cfg_data[3:0];
        REG_TIMEOUT_MS:     cfg.timeout_ms     <= cfg_data[15:0];
        REG_POSITION_LIMIT: cfg.position_limit <= cfg_data[22:0];
        REG_VELOCITY_LIMIT: cfg.velocity_limit <= cfg_data[22:0];
        REG_TORQUE_LIMIT:   cfg.torque_limit   <= cfg_data[22:0];
        default: begin
        end
      endcase
    end
  end

  assign c_ready = !out_valid || decoded.ready;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = !a_valid || b_ready;
  assign feedback.ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= feedback.valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && feedback.valid) begin
      a_item.command     <= feedback.command;
      a_item.now_ms      <= feedback.now_ms;
      a_item.extended_id <= feedback.extended_id;
      a_item.frame_id    <= feedback.frame_id;
      a_item.length_code <= feedback.length_code;
      a_item.payload     <= feedback.payload;
    end
    if (a_valid && b_ready) begin
      b_snap <= snap;
    end
    if (b_valid && c_ready) begin
      out_res <= res;
    end
  end

  mfd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (a_item),
    .step (a_valid && b_ready),
    .snap (snap)
  );

  mfd_scale u_scale (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .snap (b_snap),
    .step (b_valid && c_ready),
    .res  (res)
  );

  assign decoded.valid        = out_valid;
  assign decoded.frame_status = out_res.frame_status;
  assign decoded.motor_nibble = out_res.motor_nibble;
  assign decoded.fault_nibble = out_res.fault_nibble;
  assign decoded.position     = out_res.position;
  assign decoded.velocity     = out_res.velocity;
  assign decoded.torque       = out_res.torque;
  assign decoded.mos_temp     = out_res.mos_temp;
  assign decoded.rotor_temp   = out_res.rotor_temp;
  assign decoded.online       = out_res.online;
  assign decoded.good_count   = out_res.good_count;
  assign decoded.bad_count    = out_res.bad_count;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for motor_feedback_frame_decoder.
// Drives ticks and CAN feedback frames under random idling, predicts every decoded
// result in a scoreboard and compares field by field. Depends on mfd_pkg, both interfaces and the top level.
`timescale 1ns / 1ps

module tb;
  import mfd_pkg::*;

  typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_SLUGGISH} rx_mode_e;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  mfd_feedback_if fb ();
  mfd_decoded_if  dec ();

  motor_feedback_frame_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .feedback  (fb),
    .decoded   (dec)
  );

  mfd_cfg_t    regs;
  mfd_res_t    held;
  logic [31:0] rx_stamp;
  mfd_res_t    pending_results[$];
  int          mismatches;
  int          burst_left;
  int          status_seen[4];
  int          phases;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [23:0] scale_to_q16(logic [15:0] code, logic [22:0] lim,
                                               int unsigned w);
    logic [63:0] full;
    logic [63:0] q;
    full = (64'd1 << w) - 64'd1;
    q = (64'(code) * (64'(lim) << 1)) / full;
    return 24'(q - 64'(lim));
  endfunction

  function automatic mfd_res_t decode_item(mfd_in_t it);
    logic [31:0] elapsed;
    held.frame_status = ST_TICK;
    if (it.command) begin
      if (it.extended_id || it.frame_id != regs.feedback_id || it.length_code != FRAME_LEN) begin
        held.bad_count = held.bad_count + 32'd1;
        held.frame_status = ST_BAD_HEADER;
      end else begin
        held.motor_nibble = it.payload[59:56];
        held.fault_nibble = it.payload[63:60];
        if (held.motor_nibble != regs.expected_motor) begin
          held.bad_count = held.bad_count + 32'd1;
          held.frame_status = ST_WRONG_MOTOR;
        end else begin
          held.position = scale_to_q16(it.payload[55:40], regs.position_limit, POS_CODE_W);
          held.velocity = scale_to_q16(16'(it.payload[39:28]), regs.velocity_limit, VT_CODE_W);
          held.torque = scale_to_q16(16'(it.payload[27:16]), regs.torque_limit, VT_CODE_W);
          held.mos_temp = it.payload[15:8];
          held.rotor_temp = it.payload[7:0];
          rx_stamp = it.now_ms;
          held.good_count = held.good_count + 32'd1;
          held.online = 1'b1;
          held.frame_status = ST_ACCEPTED;
        end
      end
    end
    elapsed = it.now_ms - rx_stamp;
    if (held.online && elapsed > 32'(regs.timeout_ms)) held.online = 1'b0;
    status_seen[held.frame_status]++;
    return held;
  endfunction

  function automatic mfd_in_t tick_item(logic [31:0] now);
    mfd_in_t it;
    it.command = 1'b0;
    it.now_ms = now;
    it.extended_id = 1'($urandom_range(0, 1));
    it.frame_id = 11'($urandom_range(0, 2047));
    it.length_code = 4'($urandom_range(0, 15));
    it.payload = {$urandom, $urandom};
    return it;
  endfunction

  function automatic mfd_in_t frame_item(logic [31:0] now, logic [3:0] motor,
                                         logic [3:0] fault, logic [55:0] body);
    mfd_in_t it;
    it.command = 1'b1;
    it.now_ms = now;
    it.extended_id = 1'b0;
    it.frame_id = regs.feedback_id;
    it.length_code = FRAME_LEN;
    it.payload = {fault, motor, body};
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FEEDBACK_ID:    regs.feedback_id = val[10:0];
      REG_EXPECTED_MOTOR: regs.expected_motor = val[3:0];
      REG_TIMEOUT_MS:     regs.timeout_ms = val[15:0];
      REG_POSITION_LIMIT: regs.position_limit = val;
      REG_VELOCITY_LIMIT: regs.velocity_limit = val;
      REG_TORQUE_LIMIT:   regs.torque_limit = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(input mfd_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      fb.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
    end
    fb.valid <= 1'b1;
    fb.command <= it.command;
    fb.now_ms <= it.now_ms;
    fb.extended_id <= it.extended_id;
    fb.frame_id <= it.frame_id;
    fb.length_code <= it.length_code;
    fb.payload <= it.payload;
    do @(posedge clk); while (fb.ready !== 1'b1);
    pending_results.push_back(decode_item(it));
    burst_left--;
  endtask

  // hold the sender until every transaction has drained out
  task automatic drain();
    fb.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : receiver
    int       cyc;
    rx_mode_e mode;
    cyc = 0;
    mode = RX_FREE;
    dec.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 160 == 0) mode = rx_mode_e'($urandom_range(0, 3));
      case (mode)
        RX_FREE:     dec.ready <= 1'b1;
        RX_RANDOM:   dec.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: dec.ready <= (cyc % 5 != 0);
        default:     dec.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    mfd_res_t got;
    mfd_res_t want;
    if (!rst && dec.valid === 1'b1 && dec.ready === 1'b1) begin
      got.frame_status = dec.frame_status;
      got.motor_nibble = dec.motor_nibble;
      got.fault_nibble = dec.fault_nibble;
      got.position = dec.position;
      got.velocity = dec.velocity;
      got.torque = dec.torque;
      got.mos_temp = dec.mos_temp;
      got.rotor_temp = dec.rotor_temp;
      got.online = dec.online;
      got.good_count = dec.good_count;
      got.bad_count = dec.bad_count;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp st=%0d mot=%h flt=%h pos=%0d vel=%0d trq=%0d mos=%0d rot=%0d on=%b good=%0d bad=%0d",
                     want.frame_status, want.motor_nibble, want.fault_nibble, want.position,
                     want.velocity, want.torque, want.mos_temp, want.rotor_temp, want.online,
                     want.good_count, want.bad_count);
            $display("         act st=%0d mot=%h flt=%h pos=%0d vel=%0d trq=%0d mos=%0d rot=%0d on=%b good=%0d bad=%0d",
                     got.frame_status, got.motor_nibble, got.fault_nibble, got.position,
                     got.velocity, got.torque, got.mos_temp, got.rotor_temp, got.online,
                     got.good_count, got.bad_count);
          end
        end
      end
    end
  end

  task automatic test_header_and_status();
    mfd_in_t it;
    send_item(tick_item(32'd1000));
    send_item(frame_item(32'd1001, 4'd1, 4'hF, 56'h0));
    send_item(frame_item(32'd1002, 4'd1, 4'h0, {56{1'b1}}));
    send_item(frame_item(32'd1003, 4'd0, 4'hA, 56'h123456789ABCDE));
    it = frame_item(32'd1004, 4'd1, 4'h3, 56'h0);
    it.extended_id = 1'b1;
    send_item(it);
    it = frame_item(32'd1005, 4'd1, 4'h3, 56'h0);
    it.frame_id = 11'h7FF;
    send_item(it);
    it.length_code = 4'd0;
    it.frame_id = regs.feedback_id;
    send_item(it);
    it.length_code = 4'hF;
    send_item(it);
    it.length_code = 4'd7;
    send_item(it);
    drain();
  endtask

  task automatic test_timeout_and_wrap();
    write_reg(REG_TIMEOUT_MS, 23'd0);
    send_item(frame_item(32'd5000, 4'd1, 4'h1, 56'h8000_0800_8000_00));
    send_item(tick_item(32'd5000));
    send_item(tick_item(32'd5001));
    drain();
    write_reg(REG_TIMEOUT_MS, 23'd65535);
    send_item(frame_item(32'hFFFF_FFF0, 4'd1, 4'h2, 56'h7FFF_7FF7_FF55_AA));
    send_item(tick_item(32'h0000_FFEF));
    send_item(tick_item(32'h0000_FFF0));
    drain();
  endtask

  task automatic test_register_extremes();
    mfd_in_t it;
    write_reg(REG_FEEDBACK_ID, 23'd2047);
    write_reg(REG_EXPECTED_MOTOR, 23'd15);
    write_reg(REG_POSITION_LIMIT, 23'h7FFFFF);
    write_reg(REG_VELOCITY_LIMIT, 23'h7FFFFF);
    write_reg(REG_TORQUE_LIMIT, 23'h7FFFFF);
    send_item(frame_item(32'd9000, 4'd15, 4'hF, {56{1'b1}}));
    send_item(frame_item(32'd9001, 4'd15, 4'h0, 56'h0));
    it = frame_item(32'd9002, 4'd15, 4'h0, 56'h0);
    it.frame_id = 11'd0;
    send_item(it);
    drain();
    write_reg(REG_EXPECTED_MOTOR, 23'd0);
    write_reg(REG_POSITION_LIMIT, 23'd0);
    write_reg(REG_VELOCITY_LIMIT, 23'd0);
    write_reg(REG_TORQUE_LIMIT, 23'd0);
    send_item(frame_item(32'd9003, 4'd0, 4'h5, 56'hC3A5_5A3C_96E1_7E));
    send_item(frame_item(32'd9004, 4'd15, 4'h5, 56'h0));
    drain();
  endtask

  function automatic logic [22:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return 23'd0;
      1:       return 23'h7FFFFF;
      2:       return 23'($urandom_range(0, 2000));
      default: return 23'($urandom_range(0, 23'h7FFFFF));
    endcase
  endfunction

  task automatic program_phase();
    logic [22:0] v;
    case ($urandom_range(0, 3))
      0:       v = 23'd0;
      1:       v = 23'd2047;
      default: v = 23'($urandom_range(0, 2047));
    endcase
    write_reg(REG_FEEDBACK_ID, v);
    write_reg(REG_EXPECTED_MOTOR, 23'($urandom_range(0, 15)));
    case ($urandom_range(0, 3))
      0:       v = 23'd0;
      1:       v = 23'd65535;
      2:       v = 23'($urandom_range(1, 50));
      default: v = 23'($urandom_range(0, 65535));
    endcase
    write_reg(REG_TIMEOUT_MS, v);
    write_reg(REG_POSITION_LIMIT, pick_limit());
    write_reg(REG_VELOCITY_LIMIT, pick_limit());
    write_reg(REG_TORQUE_LIMIT, pick_limit());
  endtask

  task automatic make_random(inout logic [31:0] now, output mfd_in_t it);
    int          r;
    logic [55:0] body;
    r = $urandom_range(0, 99);
    if (r < 80) now = now + 32'($urandom_range(0, 40));
    else if (r < 95) now = now + 32'(regs.timeout_ms) + 32'($urandom_range(0, 60));
    else now = $urandom;
    case ($urandom_range(0, 9))
      0:       body = 56'h0;
      1:       body = {56{1'b1}};
      default: body = 56'({$urandom, $urandom});
    endcase
    r = $urandom_range(0, 99);
    if (r < 15) begin
      it = tick_item(now);
    end else if (r < 70) begin
      it = frame_item(now, regs.expected_motor, 4'($urandom_range(0, 15)), body);
    end else if (r < 82) begin
      it = frame_item(now, regs.expected_motor ^ 4'($urandom_range(1, 15)),
                      4'($urandom_range(0, 15)), body);
    end else begin
      it = frame_item(now, regs.expected_motor, 4'($urandom_range(0, 15)), body);
      case ($urandom_range(0, 3))
        0: it.extended_id = 1'b1;
        1: it.frame_id = regs.feedback_id ^ 11'($urandom_range(1, 2047));
        2: it.length_code = FRAME_LEN ^ 4'($urandom_range(1, 15));
        default: begin
          it.extended_id = 1'($urandom_range(0, 1));
          it.frame_id = 11'($urandom_range(0, 2047));
          it.length_code = 4'($urandom_range(0, 15));
        end
      endcase
    end
  endtask

  task automatic test_random_traffic();
    logic [31:0] now;
    mfd_in_t     it;
    for (int p = 0; p < 7; p++) begin
      drain();
      program_phase();
      phases++;
      now = $urandom;
      repeat (205) begin
        make_random(now, it);
        send_item(it);
      end
    end
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    fb.valid <= 1'b0;
    fb.command <= 1'b0;
    fb.now_ms <= '0;
    fb.extended_id <= 1'b0;
    fb.frame_id <= '0;
    fb.length_code <= '0;
    fb.payload <= '0;
    regs.feedback_id = RST_FEEDBACK_ID;
    regs.expected_motor = RST_EXPECTED_MOTOR;
    regs.timeout_ms = RST_TIMEOUT_MS;
    regs.position_limit = RST_POSITION_LIMIT;
    regs.velocity_limit = RST_VELOCITY_LIMIT;
    regs.torque_limit = RST_TORQUE_LIMIT;
    held = '0;
    rx_stamp = '0;
    mismatches = 0;
    burst_left = 0;
    phases = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_and_status();
    test_timeout_and_wrap();
    test_register_extremes();
    test_random_traffic();
    $display("covered %0d ticks, %0d accepted, %0d bad-header and %0d wrong-motor transactions",
             status_seen[ST_TICK], status_seen[ST_ACCEPTED], status_seen[ST_BAD_HEADER],
             status_seen[ST_WRONG_MOTOR]);
    $display("over %0d random register phases plus directed extremes; %0d mismatches",
             phases, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[motor_feedback_frame_decoder] OK");
    end else begin
      $display("[motor_feedback_frame_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[motor_feedback_frame_decoder] ERROR");
    $finish;
  end

endmodule
